// ===== hw/rtl/mme_pkg.sv =====
// shared types and constants of the matrix multiply engine
`timescale 1ns / 1ps

package mme_pkg;

  // fixed field widths
  localparam int ELEM_W = 32;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int ACT_W  = 2;

  // defaults of the top level parameters
  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  // reset value of each dimension register
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // saturation limits in Q16.16
  localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

  // action codes of an input transaction
  localparam logic [ACT_W-1:0] ACT_WR_A    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_B    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // input transaction
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic signed [ELEM_W-1:0] product;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     saturated;
    logic                     last;
  } out_item_t;

  // element of A travelling down the cell chain
  typedef struct packed {
    logic                     vld;
    logic                     first;
    logic                     last;
    logic [IDX_W-1:0]         k;
    logic signed [ELEM_W-1:0] a;
  } feed_t;

  // write of one B element into the chain
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic [ELEM_W-1:0]        data;
  } b_wr_t;

endpackage

// ===== hw/rtl/mme_stream_if.sv =====
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps

interface mme_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mme_cell.sv =====
// one multiply-accumulate cell holding one column of B
`timescale 1ns / 1ps

module mme_cell import mme_pkg::*; #(
  parameter int  MAX_DIM = MAX_DIM_DEF,
  localparam int ACC_W   = 2 * ELEM_W + $clog2(MAX_DIM) + 1,
  localparam int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    b_we,
  input  logic [IDX_W-1:0]        b_row,
  input  logic [ELEM_W-1:0]       b_data,
  input  feed_t                   feed_i,
  output feed_t                   feed_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic [ELEM_W-1:0]         b_mem [MAX_DIM];
  feed_t                     feed_r;
  logic                      prod_vld_r;
  logic                      prod_first_r;
  logic signed [2*ELEM_W-1:0] prod_r;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_r;

  // column store of B
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_row[IW-1:0]] <= b_data;
    end
  end

  // feed stage and product control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_r     <= '0;
      prod_vld_r <= 1'b0;
    end else begin
      feed_r     <= feed_i;
      prod_vld_r <= feed_r.vld;
    end
  end

  // product and accumulator datapath
  always_ff @(posedge clk) begin
    prod_first_r <= feed_r.first;
    prod_r       <= $signed(feed_r.a) * $signed(b_mem[feed_r.k[IW-1:0]]);
    if (prod_vld_r) begin
      acc_r <= prod_first_r ? prod_ext : acc_r + prod_ext;
    end
  end

  // sign extend the product to accumulator width
  assign prod_ext = signed'({{(ACC_W-2*ELEM_W){prod_r[2*ELEM_W-1]}}, prod_r});

  assign feed_o = feed_r;
  assign acc_o  = acc_r;

endmodule

// ===== hw/rtl/mme_chain.sv =====
// row of cells, one per result column, with the result select
`timescale 1ns / 1ps

module mme_chain import mme_pkg::*; #(
  parameter int  MAX_DIM = MAX_DIM_DEF,
  localparam int ACC_W   = 2 * ELEM_W + $clog2(MAX_DIM) + 1,
  localparam int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  b_wr_t                   b_wr,
  input  feed_t                   feed_i,
  input  logic [IDX_W-1:0]        sel_col,
  output logic signed [ACC_W-1:0] acc_sel
);

  feed_t                   feed_link [MAX_DIM+1];
  logic signed [ACC_W-1:0] acc_all   [MAX_DIM];

  assign feed_link[0] = feed_i;

  // cells pass the A element to their right neighbor every cycle
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    logic we;
    assign we = b_wr.en && (b_wr.col == IDX_W'(j));

    mme_cell #(
      .MAX_DIM (MAX_DIM)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .b_we   (we),
      .b_row  (b_wr.row),
      .b_data (b_wr.data),
      .feed_i (feed_link[j]),
      .feed_o (feed_link[j+1]),
      .acc_o  (acc_all[j])
    );
  end

  // pick the finished sum of one column
  assign acc_sel = acc_all[sel_col[IW-1:0]];

endmodule

// ===== hw/rtl/matrix_multiply_engine_core.sv =====
// top level of the matrix multiply engine: sequencer, A store and output register
`timescale 1ns / 1ps

// Dense matrix product C = A x B in signed Q16.16. A write transaction (action 0 or 1)
// stores one element of A or B; writes are accepted back to back.
// A compute transaction (action 2) produces one result per cell of C in row-major order,
// the final cell marked last; no input is accepted until the last result is loaded into
// the output register. For each row of C, one element of A is read per cycle from the
// A memory and sent down a chain of MAX_DIM multiply-accumulate cells (one per column
// of C, each holding its column of B), the sequencer then waits for the chain to
// settle, and the cell sums are drained one per cycle, while the output is not stalled,
// through the saturating output stage. Dimension registers of 0 act as 1 and values
// above MAX_DIM act as MAX_DIM. Writes with an index at or above MAX_DIM are dropped.
// Elements of A or B that were never written read as unknown values.

module matrix_multiply_engine_core import mme_pkg::*; #(
  parameter int  MAX_DIM   = MAX_DIM_DEF,
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int ACC_W     = 2 * ELEM_W + $clog2(MAX_DIM) + 1,
  localparam int IW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  mme_stream_if.sink         in_chan,
  mme_stream_if.source       out_chan,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [DIM_W-1:0]   cfg_data
);

  localparam logic [DIM_W-1:0] DIM_LIM  = DIM_W'(MAX_DIM);
  localparam int               WAIT_CYC = MAX_DIM + 4;
  localparam int               WW       = $clog2(WAIT_CYC + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DRAIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic [WW-1:0]      wait_r, wait_nxt;
  feed_t              feed_r, feed_nxt;
  logic               out_vld_r, out_vld_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [DIM_W-1:0]   rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0]   nr, nk, nc;
  logic [ELEM_W-1:0]  a_mem [MAX_DIM][MAX_DIM];
  logic [ELEM_W-1:0]  a_rd_r;

  in_item_t           in_item;
  logic               in_acc;
  logic               idx_ok;
  logic               a_we;
  b_wr_t              b_wr;
  feed_t              chain_feed;
  logic               k_end, c_end, i_end, out_free;

  logic signed [ACC_W-1:0] acc_sel;
  logic signed [ACC_W-1:0] acc_shift;
  logic                    fits;
  logic signed [ELEM_W-1:0] sat_val;

  // clamp a dimension register into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_LIM) begin
      r = DIM_LIM;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_INNER_DIM: inner_dim_r <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign nr = clamp_dim(rows_a_r);
  assign nk = clamp_dim(inner_dim_r);
  assign nc = clamp_dim(cols_b_r);

  // input handshake and element writes
  assign in_item       = in_chan.data;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign idx_ok        = ({1'b0, in_item.row_index} < DIM_LIM) &&
                         ({1'b0, in_item.col_index} < DIM_LIM);
  assign a_we          = in_acc && idx_ok && (in_item.action == ACT_WR_A);

  assign b_wr.en   = in_acc && idx_ok && (in_item.action == ACT_WR_B);
  assign b_wr.row  = in_item.row_index;
  assign b_wr.col  = in_item.col_index;
  assign b_wr.data = in_item.element;

  // A memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[in_item.row_index[IW-1:0]][in_item.col_index[IW-1:0]] <= in_item.element;
    end
    a_rd_r <= a_mem[i_r[IW-1:0]][k_r[IW-1:0]];
  end

  // chain input: issue tag with the element read in the same cycle
  always_comb begin
    chain_feed   = feed_r;
    chain_feed.a = a_rd_r;
  end

  mme_chain #(
    .MAX_DIM (MAX_DIM)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_wr    (b_wr),
    .feed_i  (chain_feed),
    .sel_col (col_r),
    .acc_sel (acc_sel)
  );

  // drop fraction bits with floor and saturate to 32 bits
  assign acc_shift = acc_sel >>> FRAC_BITS;
  assign fits      = (&acc_shift[ACC_W-1:ELEM_W-1]) || !(|acc_shift[ACC_W-1:ELEM_W-1]);
  assign sat_val   = fits ? acc_shift[ELEM_W-1:0] : (acc_sel[ACC_W-1] ? Q_MIN : Q_MAX);

  assign k_end    = ({1'b0, k_r} == nk - DIM_W'(1));
  assign c_end    = ({1'b0, col_r} == nc - DIM_W'(1));
  assign i_end    = ({1'b0, i_r} == nr - DIM_W'(1));
  assign out_free = !out_vld_r || out_chan.ready;

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    col_nxt      = col_r;
    wait_nxt     = wait_r;
    out_item_nxt = out_item_r;
    out_vld_nxt  = out_vld_r && !out_chan.ready;

    feed_nxt       = '0;
    feed_nxt.vld   = (state_r == ST_ISSUE);
    feed_nxt.first = (k_r == '0);
    feed_nxt.last  = k_end;
    feed_nxt.k     = k_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_item.action == ACT_COMPUTE)) begin
          state_nxt = ST_ISSUE;
          i_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        if (k_end) begin
          k_nxt     = '0;
          wait_nxt  = '0;
          state_nxt = ST_WAIT;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (wait_r == WW'(WAIT_CYC - 1)) begin
          col_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          wait_nxt = wait_r + WW'(1);
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_vld_nxt            = 1'b1;
          out_item_nxt.product   = sat_val;
          out_item_nxt.out_row   = i_r;
          out_item_nxt.out_col   = col_r;
          out_item_nxt.saturated = !fits;
          out_item_nxt.last      = c_end && i_end;
          if (c_end) begin
            col_nxt = '0;
            if (i_end) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt     = i_r + IDX_W'(1);
              state_nxt = ST_ISSUE;
            end
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      i_r       <= '0;
      k_r       <= '0;
      col_r     <= '0;
      wait_r    <= '0;
      feed_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      k_r       <= k_nxt;
      col_r     <= col_nxt;
      wait_r    <= wait_nxt;
      feed_r    <= feed_nxt;
      out_vld_r <= out_vld_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_item_r;

`ifndef NO_ASSERTIONS
  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_chan.ready |=> out_vld_r && $stable(out_item_r))
    else $error("stalled result changed");

  // issued inner index stays within the inner dimension
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> {1'b0, k_r} < nk)
    else $error("inner index beyond inner dimension");

  // drained column stays within the result width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> {1'b0, col_r} < nc)
    else $error("drain column beyond result columns");

  // a shown result belongs to a row of the result
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> {1'b0, out_item_r.out_row} < nr)
    else $error("result row beyond result rows");

  // a loaded result follows a finished drain step only
  a_load_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == ST_DRAIN)
    else $error("result loaded outside drain");
`endif

endmodule

// ===== dv/matrix_multiply_engine_core_tb.sv =====
// self-checking testbench of the matrix multiply engine core
`timescale 1ns / 1ps

module matrix_multiply_engine_core_tb;
  import mme_pkg::*;

  // action code that the block ignores
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam int          STORE_DEPTH   = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int unsigned ITEM_TARGET   = 460;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned REPORT_CAP    = 40;

  // mirror of the engine: stores, dimension registers and cells still due
  class matmul_scoreboard;
    logic signed [ELEM_W-1:0] a_cells [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_cells [STORE_DEPTH];
    bit                       a_known [STORE_DEPTH];
    bit                       b_known [STORE_DEPTH];
    logic [DIM_W-1:0]         dim_reg [3];
    out_item_t                cells_due [$];
    int unsigned              errors;

    function new();
      foreach (dim_reg[i]) dim_reg[i] = DIM_RESET;
      foreach (a_known[i]) begin
        a_known[i] = 1'b0;
        b_known[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void set_dim(logic [1:0] idx, logic [DIM_W-1:0] val);
      dim_reg[idx] = val;
    endfunction

    // register value as the engine uses it: 0 acts as 1, above max acts as max
    function int unsigned span(logic [1:0] idx);
      if (dim_reg[idx] == 0) return 1;
      if (dim_reg[idx] > MAX_DIM_DEF) return MAX_DIM_DEF;
      return dim_reg[idx];
    endfunction

    // exact sum of products, floor shift, saturation to Q16.16
    function out_item_t predict_cell(int unsigned i, int unsigned j, int unsigned depth);
      logic signed [71:0] acc;
      logic signed [71:0] shifted;
      longint             term;
      out_item_t          c;
      acc = '0;
      for (int unsigned k = 0; k < depth; k++) begin
        term = longint'(a_cells[i * MAX_DIM_DEF + k]) * longint'(b_cells[k * MAX_DIM_DEF + j]);
        acc += term;
      end
      shifted = acc >>> FRAC_BITS_DEF;
      c.out_row = IDX_W'(i);
      c.out_col = IDX_W'(j);
      c.last    = 1'b0;
      if (shifted > 72'sd2147483647) begin
        c.product   = Q_MAX;
        c.saturated = 1'b1;
      end else if (shifted < -72'sd2147483648) begin
        c.product   = Q_MIN;
        c.saturated = 1'b1;
      end else begin
        c.product   = shifted[ELEM_W-1:0];
        c.saturated = 1'b0;
      end
      return c;
    endfunction

    // accepted input transaction: store update or full product expansion
    function void absorb_item(in_item_t it);
      int unsigned nr;
      int unsigned nk;
      int unsigned nc;
      out_item_t   c;
      case (it.action)
        ACT_WR_A: begin
          a_cells[{it.row_index, it.col_index}] = it.element;
          a_known[{it.row_index, it.col_index}] = 1'b1;
        end
        ACT_WR_B: begin
          b_cells[{it.row_index, it.col_index}] = it.element;
          b_known[{it.row_index, it.col_index}] = 1'b1;
        end
        ACT_COMPUTE: begin
          nr = span(REG_ROWS_A);
          nk = span(REG_INNER_DIM);
          nc = span(REG_COLS_B);
          for (int unsigned i = 0; i < nr; i++) begin
            for (int unsigned j = 0; j < nc; j++) begin
              c = predict_cell(i, j, nk);
              c.last = (i == nr - 1) && (j == nc - 1);
              cells_due.push_back(c);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [ELEM_W-1:0] got, logic [ELEM_W-1:0] want);
      if (errors < REPORT_CAP)
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    // accepted result transaction against the oldest cell due
    task match_cell(out_item_t got);
      out_item_t want;
      if (cells_due.size() == 0) begin
        report_mismatch("result with nothing due", got.product, '0);
        return;
      end
      want = cells_due.pop_front();
      if (got.product !== want.product)
        report_mismatch($sformatf("product (%0d,%0d)", want.out_row, want.out_col),
                        got.product, want.product);
      if (got.out_row !== want.out_row)
        report_mismatch("out_row", ELEM_W'(got.out_row), ELEM_W'(want.out_row));
      if (got.out_col !== want.out_col)
        report_mismatch("out_col", ELEM_W'(got.out_col), ELEM_W'(want.out_col));
      if (got.saturated !== want.saturated)
        report_mismatch($sformatf("saturated (%0d,%0d)", want.out_row, want.out_col),
                        ELEM_W'(got.saturated), ELEM_W'(want.saturated));
      if (got.last !== want.last)
        report_mismatch($sformatf("last (%0d,%0d)", want.out_row, want.out_col),
                        ELEM_W'(got.last), ELEM_W'(want.last));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [DIM_W-1:0] cfg_data;

  mme_stream_if #(.payload_t(in_item_t))  in_chan ();
  mme_stream_if #(.payload_t(out_item_t)) out_chan ();

  matmul_scoreboard sb = new();

  bit          offering;
  bit          hold_req;
  bit          calm_in;
  bit          calm_out;
  int unsigned loaded;

  matrix_multiply_engine_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // element mix: small values, boundary values and full-range noise
  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: return int'($urandom_range(0, 2 ** 21)) - (2 ** 20);
    endcase
  endfunction

  // dimension register value, extremes and out-of-range values included
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      3: return 4'd1;
      4: return DIM_W'($urandom_range(9, 14));
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  // one input transaction, with a random gap before it
  task automatic push_item(in_item_t it);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      if (offering) in_chan.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    offering = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    sb.absorb_item(it);
    if (it.action != ACT_NONE) loaded++;
  endtask

  task automatic write_elem(logic [ACT_W-1:0] act, int unsigned r, int unsigned c,
                            logic signed [ELEM_W-1:0] v);
    in_item_t it;
    it.action    = act;
    it.row_index = IDX_W'(r);
    it.col_index = IDX_W'(c);
    it.element   = v;
    push_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it.action    = ACT_NONE;
    it.row_index = IDX_W'($urandom);
    it.col_index = IDX_W'($urandom);
    it.element   = $urandom;
    push_item(it);
  endtask

  // product request; any element the product reads is written first
  task automatic run_product();
    int unsigned nr;
    int unsigned nk;
    int unsigned nc;
    in_item_t    it;
    nr = sb.span(REG_ROWS_A);
    nk = sb.span(REG_INNER_DIM);
    nc = sb.span(REG_COLS_B);
    for (int unsigned i = 0; i < nr; i++)
      for (int unsigned k = 0; k < nk; k++)
        if (!sb.a_known[i * MAX_DIM_DEF + k]) write_elem(ACT_WR_A, i, k, rand_elem());
    for (int unsigned k = 0; k < nk; k++)
      for (int unsigned j = 0; j < nc; j++)
        if (!sb.b_known[k * MAX_DIM_DEF + j]) write_elem(ACT_WR_B, k, j, rand_elem());
    it.action    = ACT_COMPUTE;
    it.row_index = IDX_W'($urandom);
    it.col_index = IDX_W'($urandom);
    it.element   = $urandom;
    push_item(it);
  endtask

  // stop offering, wait for every due cell, then let the engine settle
  task automatic go_idle(int unsigned settle);
    if (offering) in_chan.valid <= 1'b0;
    offering = 1'b0;
    while (sb.cells_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_A;
    cfg_data  <= r;
    sb.set_dim(REG_ROWS_A, r);
    @(posedge clk);
    cfg_index <= REG_INNER_DIM;
    cfg_data  <= k;
    sb.set_dim(REG_INNER_DIM, k);
    @(posedge clk);
    cfg_index <= REG_COLS_B;
    cfg_data  <= c;
    sb.set_dim(REG_COLS_B, c);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int unsigned hold;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        hold = calm_out ? 0 : $urandom_range(0, 6);
      end
      if (hold != 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      sb.match_cell(out_chan.data);
    end
  end

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned sel;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ROWS_A;
    cfg_data      <= '0;
    offering = 1'b0;
    hold_req = 1'b0;
    calm_in  = 1'b0;
    calm_out = 1'b0;
    loaded   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-cell products around the saturation limits
    set_dims(4'd1, 4'd1, 4'd1);
    write_elem(ACT_WR_A, 0, 0, 32'h7FFF_FFFF);
    write_elem(ACT_WR_B, 0, 0, 32'h7FFF_FFFF);
    run_product();
    write_elem(ACT_WR_B, 0, 0, 32'h8000_0000);
    run_product();
    write_elem(ACT_WR_A, 0, 0, 32'h8000_0000);
    run_product();
    // exact minimum and maximum, no saturation
    write_elem(ACT_WR_B, 0, 0, 32'h0001_0000);
    run_product();
    write_elem(ACT_WR_A, 0, 0, 32'h7FFF_FFFF);
    run_product();
    // tiny negative product rounds toward minus infinity
    write_elem(ACT_WR_A, 0, 0, 32'h0000_0001);
    write_elem(ACT_WR_B, 0, 0, 32'hFFFF_FFFF);
    run_product();
    // ignored action and the far corner of both stores
    send_noise();
    write_elem(ACT_WR_A, 7, 7, 32'h8000_0000);
    write_elem(ACT_WR_B, 7, 7, 32'h7FFF_FFFF);
    // zero dimensions act as one
    go_idle(SETTLE_CYCLES);
    set_dims(4'd0, 4'd0, 4'd0);
    run_product();

    // random phases, each under its own dimension setting
    phase = 0;
    while (loaded < ITEM_TARGET) begin
      go_idle(SETTLE_CYCLES);
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // full-size product with the result side held off while inputs keep coming
        set_dims(4'd8, 4'd8, 4'd8);
        hold_req = 1'b1;
        run_product();
        repeat (6) write_elem($urandom_range(0, 1) ? ACT_WR_B : ACT_WR_A,
                              $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
      end else begin
        set_dims(pick_dim(), pick_dim(), pick_dim());
      end
      repeat ($urandom_range(8, 30)) begin
        sel = $urandom_range(0, 99);
        if (sel < 6)
          send_noise();
        else if (sel < 20)
          run_product();
        else
          write_elem($urandom_range(0, 1) ? ACT_WR_B : ACT_WR_A,
                     $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
      end
      phase++;
    end

    go_idle(DRAIN_CYCLES);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mme_pkg.sv
hw/rtl/mme_stream_if.sv
hw/rtl/mme_cell.sv
hw/rtl/mme_chain.sv
hw/rtl/matrix_multiply_engine_core.sv
dv/matrix_multiply_engine_core_tb.sv
